>>> sv/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper package
// Shared types, register indexes and saturation helper.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int NORM_FRAC = 30;
    localparam int DIV_STEPS = 31;
    localparam int BUF_DEPTH = 4;
    localparam logic [30:0] FRAC_ONE = 31'h4000_0000;

    localparam logic [2:0] REG_NORMAL_X     = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [2:0] REG_KEEP_EPSILON = 3'd4;

    typedef struct packed {
        logic       load;
        logic       mac;
        logic       dist_ld;
        logic       div_init;
        logic       div_step;
        logic       lerp;
        logic       push_mid;
        logic       push_keep;
        logic       store;
        logic       close;
        logic       pop;
        logic       edge_sel;
        logic [1:0] axis;
    } ppc_cmd_t;

    typedef struct packed {
        logic split;
        logic open;
        logic last;
        logic drain_done;
        logic out_free;
    } ppc_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -67'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> sv/ppc_dp.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper datapath
// Configuration, vertex state, shared multiplier, divider, result buffer and
// output register.
// ----------------------------------------------------------------------------
module ppc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ppc_pkg::ppc_cmd_t   cmd,
    output ppc_pkg::ppc_sts_t   sts,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic [95:0]         s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [95:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import ppc_pkg::*;

    logic signed [31:0] nx_reg, ny_reg, nz_reg, offset_reg;
    logic [30:0]        eps_reg;

    logic signed [31:0] vin_reg   [3];
    logic signed [31:0] first_reg [3];
    logic signed [31:0] prev_reg  [3];
    logic signed [31:0] mid_reg   [3];
    logic signed [31:0] d_reg, fd_reg, pd_reg;
    logic               last_reg, open_reg;

    logic signed [65:0] prod_reg, acc_reg;
    logic [34:0]        rem_reg;
    logic [32:0]        den_reg;
    logic [30:0]        q_reg;

    logic signed [31:0] buf_xyz_reg [BUF_DEPTH][3];
    logic               buf_cross_reg [BUF_DEPTH];
    logic               buf_valid_reg [BUF_DEPTH];
    logic [2:0]         cnt_reg, rd_reg;

    logic               m_tvalid_reg, run_last_reg, poly_last_reg, cross_reg, vvalid_reg;
    logic signed [31:0] out_reg [3];

    // Edge operands: previous -> current, or current -> first for the closing edge.
    logic signed [31:0] ea [3];
    logic signed [31:0] eb [3];
    logic signed [31:0] eda, edb;
    logic signed [32:0] ediff;
    logic [32:0]        num, den;
    logic               ge;
    logic [34:0]        rem_sub;
    logic [30:0]        frac;
    logic               keep_end;
    logic signed [32:0] mul_a, mul_b;
    logic signed [31:0] n_sel, v_sel;
    logic signed [32:0] delta [3];
    logic signed [66:0] dist_sum, lerp_sum;
    logic [1:0]         axm1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = cmd.edge_sel ? vin_reg[i] : prev_reg[i];
            eb[i] = cmd.edge_sel ? first_reg[i] : vin_reg[i];
            delta[i] = 33'(eb[i]) - 33'(ea[i]);
        end
        eda = cmd.edge_sel ? d_reg : pd_reg;
        edb = cmd.edge_sel ? fd_reg : d_reg;
        ediff = 33'(eda) - 33'(edb);
        num = eda[31] ? 33'(-33'(eda)) : 33'(eda);
        den = ediff[32] ? 33'(-ediff) : 33'(ediff);
        sts.split = !(((eda > 0) && (edb > 0)) || ((eda < 0) && (edb < 0)));
        keep_end = 33'(edb) < -33'($signed({2'b00, eps_reg}));
        ge = rem_reg >= {2'b00, den_reg};
        rem_sub = ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;
        if (den_reg == 33'd0)
        begin
            frac = '0;
        end
        else
        begin
            frac = (q_reg > FRAC_ONE) ? FRAC_ONE : q_reg;
        end
        case (cmd.axis)
            2'd0:    begin n_sel = nx_reg; v_sel = vin_reg[0]; end
            2'd1:    begin n_sel = ny_reg; v_sel = vin_reg[1]; end
            2'd2:    begin n_sel = nz_reg; v_sel = vin_reg[2]; end
            default: begin n_sel = '0;     v_sel = '0;         end
        endcase
        if (cmd.mac)
        begin
            mul_a = 33'(n_sel);
            mul_b = 33'(v_sel);
        end
        else
        begin
            mul_a = (cmd.axis == 2'd3) ? 33'sd0 : delta[cmd.axis];
            mul_b = $signed({2'b00, frac});
        end
        axm1 = cmd.axis - 2'd1;
        dist_sum = 67'(acc_reg >>> NORM_FRAC) + 67'(offset_reg);
        lerp_sum = 67'(ea[axm1]) + 67'(prod_reg >>> NORM_FRAC);
        sts.open = open_reg;
        sts.last = last_reg;
        sts.drain_done = rd_reg == cnt_reg;
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= 32'sh4000_0000;
            offset_reg <= '0;
            eps_reg <= 31'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NORMAL_X:     nx_reg <= cfg_wdata;
                REG_NORMAL_Y:     ny_reg <= cfg_wdata;
                REG_NORMAL_Z:     nz_reg <= cfg_wdata;
                REG_PLANE_OFFSET: offset_reg <= cfg_wdata;
                REG_KEEP_EPSILON: eps_reg <= cfg_wdata[30:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            cnt_reg <= '0;
            rd_reg <= '0;
            m_tvalid_reg <= 1'b0;
            last_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                first_reg[i] <= '0;
                prev_reg[i] <= '0;
            end
            fd_reg <= '0;
            pd_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= s_tlast;
                cnt_reg <= '0;
                rd_reg <= '0;
            end
            if (cmd.store)
            begin
                if (!open_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        first_reg[i] <= vin_reg[i];
                    end
                    fd_reg <= d_reg;
                end
                for (int i = 0; i < 3; i++)
                begin
                    prev_reg[i] <= vin_reg[i];
                end
                pd_reg <= d_reg;
                open_reg <= 1'b1;
            end
            if (cmd.push_mid || (cmd.push_keep && keep_end) || (cmd.close && cnt_reg == '0))
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (cmd.close)
            begin
                open_reg <= 1'b0;
            end
            if (cmd.pop)
            begin
                m_tvalid_reg <= 1'b1;
                rd_reg <= rd_reg + 3'd1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vin_reg[0] <= s_tdata[31:0];
            vin_reg[1] <= s_tdata[63:32];
            vin_reg[2] <= s_tdata[95:64];
            acc_reg <= '0;
            prod_reg <= '0;
        end
        if (cmd.mac)
        begin
            prod_reg <= mul_a * mul_b;
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.dist_ld)
        begin
            d_reg <= sat32(dist_sum);
        end
        if (cmd.div_init)
        begin
            rem_reg <= {2'b00, num};
            den_reg <= den;
            q_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[33:0], 1'b0};
            q_reg <= {q_reg[29:0], ge};
        end
        if (cmd.lerp)
        begin
            prod_reg <= mul_a * mul_b;
            if (cmd.axis != 2'd0)
            begin
                mid_reg[axm1] <= sat32(lerp_sum);
            end
        end
        if (cmd.push_mid)
        begin
            buf_xyz_reg[cnt_reg[1:0]] <= mid_reg;
            buf_cross_reg[cnt_reg[1:0]] <= 1'b1;
            buf_valid_reg[cnt_reg[1:0]] <= 1'b1;
        end
        if (cmd.push_keep && keep_end)
        begin
            buf_xyz_reg[cnt_reg[1:0]] <= eb;
            buf_cross_reg[cnt_reg[1:0]] <= 1'b0;
            buf_valid_reg[cnt_reg[1:0]] <= 1'b1;
        end
        if (cmd.close && cnt_reg == '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                buf_xyz_reg[0][i] <= '0;
            end
            buf_cross_reg[0] <= 1'b0;
            buf_valid_reg[0] <= 1'b0;
        end
        if (cmd.pop)
        begin
            out_reg <= buf_xyz_reg[rd_reg[1:0]];
            cross_reg <= buf_cross_reg[rd_reg[1:0]];
            vvalid_reg <= buf_valid_reg[rd_reg[1:0]];
            run_last_reg <= (rd_reg + 3'd1) == cnt_reg;
            poly_last_reg <= ((rd_reg + 3'd1) == cnt_reg) && last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser = {run_last_reg, vvalid_reg, cross_reg};
    assign m_tlast = poly_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("result buffer overfilled");
    a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> rd_reg < cnt_reg) else $error("pop beyond buffered results");
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lerp |-> frac <= FRAC_ONE) else $error("fraction above one");
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> sts.out_free) else $error("output register overwritten");

endmodule

>>> sv/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper controller
// Sequences distance, edge division, interpolation and result drain.
// ----------------------------------------------------------------------------
module ppc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ppc_pkg::ppc_sts_t sts,
    output ppc_pkg::ppc_cmd_t cmd
);
    import ppc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DOT   = 11'b00000000010,
        S_DIST  = 11'b00000000100,
        S_EDGE  = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_LERP  = 11'b00000100000,
        S_PUSHX = 11'b00001000000,
        S_KEEP  = 11'b00010000000,
        S_STORE = 11'b00100000000,
        S_CLOSE = 11'b01000000000,
        S_DRAIN = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.edge_sel = sel_reg;
        cmd.axis = cnt_reg[1:0];
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                // Three products, then a final step that folds the last product into the sum.
                cmd.mac = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.dist_ld = 1'b1;
                sel_next = 1'b0;
                state_next = sts.open ? S_EDGE : S_STORE;
            end
            S_EDGE:
            begin
                cmd.div_init = 1'b1;
                cnt_next = '0;
                state_next = sts.split ? S_DIV : S_KEEP;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                cmd.lerp = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    state_next = S_PUSHX;
                end
            end
            S_PUSHX:
            begin
                cmd.push_mid = 1'b1;
                state_next = S_KEEP;
            end
            S_KEEP:
            begin
                cmd.push_keep = 1'b1;
                state_next = sel_reg ? S_CLOSE : S_STORE;
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.last)
                begin
                    sel_next = 1'b1;
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_CLOSE:
            begin
                cmd.close = 1'b1;
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (sts.drain_done)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.pop = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> cnt_reg < 5'(DIV_STEPS)) else $error("divider overrun");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> s_tready) else $error("load outside idle");
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> sts.last) else $error("closing edge without last vertex");

endmodule

>>> sv/polygon_plane_clipper.sv
// ----------------------------------------------------------------------------
// Polygon plane clipper
// Clips a streamed polygon against one configured plane.
// ----------------------------------------------------------------------------
// Vertices enter on the s_ channel, one item per vertex, s_tlast on the final
// vertex of a polygon. Clipped vertices leave on the m_ channel; m_tlast marks
// the last item of the clipped polygon, m_tuser[2] the last item caused by one
// input vertex. A polygon that clips away entirely ends with one item whose
// vertex_valid bit is clear.
// An input vertex runs a dot product and a distance step, then its edges. A
// plane-crossing edge runs the 31-step restoring divider that finds the
// crossing fraction, followed by a 3-axis interpolation on the shared
// multiplier. The last vertex also takes the closing edge, then a closing step.
// Results are buffered, then drained into an output register at one item per
// cycle while the receiver takes them.
// s_tready is high only between vertices. When the receiver stalls, the block
// waits in its drain phase; the final item of a vertex may still sit in the
// output register while the next vertex is being processed.
// Reset restores the register defaults (plane z = 0) and starts a new polygon.
// Configuration writes are taken at any cycle via cfg_we.
// ----------------------------------------------------------------------------
module polygon_plane_clipper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // in_x, in_y, in_z
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_x, out_y, out_z
    output logic [2:0]  m_tuser,   // is_crossing, vertex_valid, run_last
    output logic        m_tlast
);
    import ppc_pkg::*;

    ppc_cmd_t cmd;
    ppc_sts_t sts;

    ppc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
